// ----- sv/arci_pkg.sv -----
// ----------------------------------------------------------------------------
// arci_pkg: shared types and constants for the AHCI read command issuer
// Result kinds, status codes, default parameter values, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package arci_pkg;

  // Default values for the top-level parameters.
  localparam int DEFAULT_SLOT_COUNT        = 32;
  localparam int DEFAULT_SECTORS_PER_ENTRY = 16;
  localparam int DEFAULT_MAX_SECTORS       = 1024;

  // The largest scatter table has this many entries.
  localparam int MAX_ENTRIES = 64;

  // Timeout limit after reset.
  localparam logic [19:0] TIMEOUT_RESET = 20'hfffff;

  // Bit positions in the port registers.
  localparam int TF_BUSY_BIT = 7;
  localparam int TF_DRQ_BIT  = 3;
  localparam int IS_TFE_BIT  = 30;

  // Largest value of the byte count field.
  localparam logic [16:0] BCF_MAX = 17'd8191;

  // Input function codes.
  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ENTRY  = 2'd0;
  localparam logic [1:0] KIND_ISSUE  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Finish status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NO_SLOT       = 3'd1;
  localparam logic [2:0] ST_READY_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_DONE_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_TF_ERROR      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_input;
    logic       start_run;
    logic       load_entry;
    logic       load_issue;
    logic       load_finish;
    logic [2:0] fin_status;
    logic       wc_inc;
    logic       wc_clear;
  } arci_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func;
    logic slot_found;
    logic timeout;
    logic tf_busy;
    logic tf_error;
    logic issue_pending;
    logic last_entry;
    logic out_free;
  } arci_sts_t;

endpackage

// ----- sv/arci_ctrl.sv -----
// ----------------------------------------------------------------------------
// arci_ctrl: sequencing controller of the AHCI read command issuer
// Accepts one request at a time, decides what it causes from the datapath
// status, walks the scatter entries and tracks the phase of the command.
// ----------------------------------------------------------------------------
module arci_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  arci_pkg::arci_sts_t sts,
  output arci_pkg::arci_cmd_t cmd
);
  import arci_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_ENTRY = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_READY = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  assign in_ready = (state == S_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    cmd             = '0;
    cmd.fin_status  = ST_OK;
    cmd.latch_input = in_valid && (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end

      // Everything a request does happens once the output register is free.
      S_EVAL: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          if (sts.func == FUNC_START) begin
            if (!sts.slot_found) begin
              cmd.load_finish = 1'b1;
              cmd.fin_status  = ST_NO_SLOT;
              cmd.wc_clear    = 1'b1;
              phase_next      = PH_IDLE;
            end else begin
              cmd.start_run = 1'b1;
              cmd.wc_clear  = 1'b1;
              phase_next    = PH_READY;
              state_next    = S_ENTRY;
            end
          end else begin
            case (phase)
              PH_READY: begin
                if (sts.timeout) begin
                  cmd.load_finish = 1'b1;
                  cmd.fin_status  = ST_READY_TIMEOUT;
                  cmd.wc_clear    = 1'b1;
                  phase_next      = PH_IDLE;
                end else if (sts.tf_busy) begin
                  cmd.wc_inc = 1'b1;
                end else begin
                  cmd.load_issue = 1'b1;
                  cmd.wc_clear   = 1'b1;
                  phase_next     = PH_DONE;
                end
              end
              PH_DONE: begin
                if (sts.timeout) begin
                  cmd.load_finish = 1'b1;
                  cmd.fin_status  = ST_DONE_TIMEOUT;
                  cmd.wc_clear    = 1'b1;
                  phase_next      = PH_IDLE;
                end else if (sts.tf_error) begin
                  cmd.load_finish = 1'b1;
                  cmd.fin_status  = ST_TF_ERROR;
                  cmd.wc_clear    = 1'b1;
                  phase_next      = PH_IDLE;
                end else if (sts.issue_pending) begin
                  cmd.wc_inc = 1'b1;
                end else begin
                  cmd.load_finish = 1'b1;
                  cmd.fin_status  = ST_OK;
                  cmd.wc_clear    = 1'b1;
                  phase_next      = PH_IDLE;
                end
              end
              default: begin
                // A sample with no run pending is dropped.
              end
            endcase
          end
        end
      end

      // One scatter entry per cycle while the output register drains.
      S_ENTRY: begin
        if (sts.out_free) begin
          cmd.load_entry = 1'b1;
          if (sts.last_entry) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/arci_dp.sv -----
// ----------------------------------------------------------------------------
// arci_dp: datapath of the AHCI read command issuer
// Holds the accepted request, the run registers, the timeout counter and the
// output register, and reports conditions to the controller.
// ----------------------------------------------------------------------------
module arci_dp #(
  parameter int SLOT_COUNT        = arci_pkg::DEFAULT_SLOT_COUNT,
  parameter int SECTORS_PER_ENTRY = arci_pkg::DEFAULT_SECTORS_PER_ENTRY,
  parameter int MAX_SECTORS       = arci_pkg::DEFAULT_MAX_SECTORS
) (
  input  logic                clk,
  input  logic                rst,
  input  arci_pkg::arci_cmd_t cmd,
  output arci_pkg::arci_sts_t sts,
  input  logic                cfg_write_en,
  input  logic [19:0]         cfg_write_data,
  input  logic                func,
  input  logic [31:0]         buffer_address,
  input  logic [47:0]         start_lba,
  input  logic [10:0]         sector_count,
  input  logic [31:0]         active_slots,
  input  logic [31:0]         issued_slots,
  input  logic [7:0]          task_file_status,
  input  logic [31:0]         interrupt_status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [4:0]          slot,
  output logic [5:0]          entry_index,
  output logic [31:0]         data_address,
  output logic [12:0]         byte_count_field,
  output logic [47:0]         fis_lba,
  output logic [10:0]         fis_count,
  output logic [2:0]          status,
  output logic                last
);
  import arci_pkg::*;

  localparam int CountCap = (MAX_SECTORS < MAX_ENTRIES * SECTORS_PER_ENTRY) ?
                            MAX_SECTORS : MAX_ENTRIES * SECTORS_PER_ENTRY;
  localparam logic [10:0] CapW   = 11'(CountCap);
  localparam logic [10:0] SpeW   = 11'(SECTORS_PER_ENTRY);
  localparam logic [31:0] Stride = 32'(SECTORS_PER_ENTRY * 512);

  // Accepted request.
  logic        lat_func;
  logic [31:0] lat_buf;
  logic [47:0] lat_lba;
  logic [10:0] lat_count;
  logic [31:0] lat_active;
  logic [31:0] lat_issued;
  logic [7:0]  lat_tfs;
  logic [31:0] lat_int;

  // Run registers.
  logic [19:0] timeout_limit;
  logic [19:0] wait_counter;
  logic [4:0]  chosen_slot;
  logic [47:0] held_lba;
  logic [10:0] held_count;
  logic [10:0] rem_sectors;
  logic [31:0] entry_addr;
  logic [5:0]  entry_pos;

  // Derived values.
  logic [31:0] free_slots;
  logic        slot_found;
  logic [4:0]  free_slot;
  logic [10:0] cnt_sat;
  logic [7:0]  secs;
  logic [16:0] bytes_m1;
  logic [12:0] bcf;
  logic        any_load;

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.latch_input) begin
      lat_func   <= func;
      lat_buf    <= buffer_address;
      lat_lba    <= start_lba;
      lat_count  <= sector_count;
      lat_active <= active_slots;
      lat_issued <= issued_slots;
      lat_tfs    <= task_file_status;
      lat_int    <= interrupt_status;
    end
  end

  // Lowest free command slot below the slot count.
  always_comb begin
    free_slots = ~(lat_active | lat_issued);
    slot_found = 1'b0;
    free_slot  = '0;
    for (int i = 31; i >= 0; i--) begin
      if (i < SLOT_COUNT && free_slots[i]) begin
        slot_found = 1'b1;
        free_slot  = 5'(i);
      end
    end
  end

  // Sector count clamped to the supported range.
  always_comb begin
    if (lat_count == 11'd0) begin
      cnt_sat = 11'd1;
    end else if (lat_count > CapW) begin
      cnt_sat = CapW;
    end else begin
      cnt_sat = lat_count;
    end
  end

  // Size of the current scatter entry.
  always_comb begin
    secs     = (rem_sectors > SpeW) ? SpeW[7:0] : rem_sectors[7:0];
    bytes_m1 = {secs, 9'd0} - 17'd1;
    bcf      = (bytes_m1 > BCF_MAX) ? BCF_MAX[12:0] : bytes_m1[12:0];
  end

  // Timeout limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_write_en) begin
      timeout_limit <= cfg_write_data;
    end
  end

  // Wait counter, shared by both polling phases.
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_counter <= '0;
    end else if (cmd.wc_clear) begin
      wait_counter <= '0;
    end else if (cmd.wc_inc) begin
      wait_counter <= wait_counter + 20'd1;
    end
  end

  // Run state taken at a start and advanced by the entry walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      chosen_slot <= '0;
      held_lba    <= '0;
      held_count  <= '0;
    end else if (cmd.start_run) begin
      chosen_slot <= free_slot;
      held_lba    <= lat_lba;
      held_count  <= cnt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      rem_sectors <= cnt_sat;
      entry_addr  <= lat_buf;
      entry_pos   <= '0;
    end else if (cmd.load_entry) begin
      rem_sectors <= rem_sectors - SpeW;
      entry_addr  <= entry_addr + Stride;
      entry_pos   <= entry_pos + 6'd1;
    end
  end

  // Output register.
  assign any_load = cmd.load_entry || cmd.load_issue || cmd.load_finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (any_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (any_load) begin
      kind             <= KIND_ENTRY;
      slot             <= chosen_slot;
      entry_index      <= '0;
      data_address     <= '0;
      byte_count_field <= '0;
      fis_lba          <= '0;
      fis_count        <= '0;
      status           <= ST_OK;
      last             <= 1'b0;
      if (cmd.load_entry) begin
        entry_index      <= entry_pos;
        data_address     <= entry_addr;
        byte_count_field <= bcf;
      end else if (cmd.load_issue) begin
        kind      <= KIND_ISSUE;
        fis_lba   <= held_lba;
        fis_count <= held_count;
      end else begin
        kind   <= KIND_FINISH;
        status <= cmd.fin_status;
        last   <= 1'b1;
        if (cmd.fin_status == ST_NO_SLOT) begin
          slot <= '0;
        end
      end
    end
  end

  // Conditions for the controller.
  always_comb begin
    sts.func          = lat_func;
    sts.slot_found    = slot_found;
    sts.timeout       = (wait_counter >= timeout_limit);
    sts.tf_busy       = lat_tfs[TF_BUSY_BIT] | lat_tfs[TF_DRQ_BIT];
    sts.tf_error      = lat_int[IS_TFE_BIT];
    sts.issue_pending = lat_issued[chosen_slot];
    sts.last_entry    = (rem_sectors <= SpeW);
    sts.out_free      = !out_valid || out_ready;
  end

endmodule

// ----- sv/ahci_read_command_issuer.sv -----
// ----------------------------------------------------------------------------
// ahci_read_command_issuer: host side of one READ DMA EXT command on a port
// A start request builds the scatter entries and holds the LBA and count;
// status samples then issue the command and watch for its completion.
// ----------------------------------------------------------------------------
// A request is taken into the request register while the controller is idle
// and is acted on once the output register is free. A start that finds a slot
// then walks its scatter entries (up to 64) through the single output register,
// loading each one as that register is free.
// Reset clears the controller, the output valid and the wait counter, and
// sets the timeout limit to 0xfffff; no clearing pass is needed.
module ahci_read_command_issuer #(
  parameter int SLOT_COUNT        = arci_pkg::DEFAULT_SLOT_COUNT,
  parameter int SECTORS_PER_ENTRY = arci_pkg::DEFAULT_SECTORS_PER_ENTRY,
  parameter int MAX_SECTORS       = arci_pkg::DEFAULT_MAX_SECTORS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [19:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] buffer_address,
  input  logic [47:0] start_lba,
  input  logic [10:0] sector_count,
  input  logic [31:0] active_slots,
  input  logic [31:0] issued_slots,
  input  logic [7:0]  task_file_status,
  input  logic [31:0] interrupt_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [4:0]  slot,
  output logic [5:0]  entry_index,
  output logic [31:0] data_address,
  output logic [12:0] byte_count_field,
  output logic [47:0] fis_lba,
  output logic [10:0] fis_count,
  output logic [2:0]  status,
  output logic        last
);
  import arci_pkg::*;

  arci_cmd_t cmd;
  arci_sts_t sts;

  // Controller.
  arci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  arci_dp #(
    .SLOT_COUNT        (SLOT_COUNT),
    .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY),
    .MAX_SECTORS       (MAX_SECTORS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .func             (func),
    .buffer_address   (buffer_address),
    .start_lba        (start_lba),
    .sector_count     (sector_count),
    .active_slots     (active_slots),
    .issued_slots     (issued_slots),
    .task_file_status (task_file_status),
    .interrupt_status (interrupt_status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .slot             (slot),
    .entry_index      (entry_index),
    .data_address     (data_address),
    .byte_count_field (byte_count_field),
    .fis_lba          (fis_lba),
    .fis_count        (fis_count),
    .status           (status),
    .last             (last)
  );

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load_entry || cmd.load_issue || cmd.load_finish) |-> (!out_valid || out_ready))
    else $error("result loaded over a held result");

  // At most one kind of result is loaded in a cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_entry, cmd.load_issue, cmd.load_finish}))
    else $error("more than one result loaded");

  // The entry walk keeps new requests out.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_entry |-> !in_ready)
    else $error("request taken during the entry walk");

  // Only a finish result is marked last.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_FINISH)))
    else $error("last flag does not match result kind");

  // The output is empty right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the AHCI read command issuer
// Start and status-sample requests go in through a valid/ready port. A local
// predictor works out every scatter entry, issue and finish result as each
// request is accepted. The results that come out are compared in order,
// field by field, while both sides idle and stall in changing patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arci_pkg::*;

  localparam int SPE            = DEFAULT_SECTORS_PER_ENTRY;
  localparam int ENTRY_BYTES    = SPE * 512;
  localparam int SECTOR_LIMIT   = (DEFAULT_MAX_SECTORS < MAX_ENTRIES * SPE) ?
                                  DEFAULT_MAX_SECTORS : MAX_ENTRIES * SPE;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_READY = 3'b010,
    PH_DONE  = 3'b100
  } run_phase_t;
  typedef enum bit {ROW_REQUEST, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    logic        func;
    logic [31:0] buffer_address;
    logic [47:0] start_lba;
    logic [10:0] sector_count;
    logic [31:0] active_slots;
    logic [31:0] issued_slots;
    logic [7:0]  task_file_status;
    logic [31:0] interrupt_status;
  } rd_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [5:0]  entry_index;
    logic [31:0] data_address;
    logic [12:0] byte_count_field;
    logic [47:0] fis_lba;
    logic [10:0] fis_count;
    logic [2:0]  status;
    logic        last;
  } rd_res_t;

  typedef struct {
    row_kind_t   row_kind;
    logic [19:0] limit;
    rd_req_t     req;
    bit          has_exp;
    rd_res_t     exp;
  } dir_row_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_write_en   = 1'b0;
  logic [19:0] cfg_write_data = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  rd_req_t     req_bus        = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [1:0]  kind;
  logic [4:0]  slot;
  logic [5:0]  entry_index;
  logic [31:0] data_address;
  logic [12:0] byte_count_field;
  logic [47:0] fis_lba;
  logic [10:0] fis_count;
  logic [2:0]  status;
  logic        last;

  // Predictor state, mirroring the block's registers.
  logic [19:0] limit_m    = TIMEOUT_RESET;
  run_phase_t  run_phase  = PH_IDLE;
  logic [4:0]  run_slot   = '0;
  int unsigned wait_count = 0;
  logic [47:0] run_lba    = '0;
  logic [10:0] run_count  = '0;

  rd_res_t  awaited_results[$];
  rd_res_t  last_predicted = '0;
  dir_row_t directed_rows[$];

  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  ahci_read_command_issuer i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (req_bus.func),
    .buffer_address   (req_bus.buffer_address),
    .start_lba        (req_bus.start_lba),
    .sector_count     (req_bus.sector_count),
    .active_slots     (req_bus.active_slots),
    .issued_slots     (req_bus.issued_slots),
    .task_file_status (req_bus.task_file_status),
    .interrupt_status (req_bus.interrupt_status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .slot             (slot),
    .entry_index      (entry_index),
    .data_address     (data_address),
    .byte_count_field (byte_count_field),
    .fis_lba          (fis_lba),
    .fis_count        (fis_count),
    .status           (status),
    .last             (last)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic rd_res_t pack_result(input logic [1:0] k, input logic [4:0] s,
                                          input logic [5:0] idx, input logic [31:0] addr,
                                          input logic [12:0] bcf, input logic [47:0] lba,
                                          input logic [10:0] cnt, input logic [2:0] st,
                                          input logic fin);
    return {k, s, idx, addr, bcf, lba, cnt, st, fin};
  endfunction

  function automatic void post_result(input rd_res_t r);
    awaited_results.push_back(r);
    last_predicted = r;
  endfunction

  // A finish result always closes the run and clears the wait counter.
  function automatic void close_run(input logic [4:0] s, input logic [2:0] st);
    post_result(pack_result(KIND_FINISH, s, '0, '0, '0, '0, '0, st, 1'b1));
    run_phase  = PH_IDLE;
    wait_count = 0;
  endfunction

  // Advance the predictor by one accepted request and queue its results.
  function automatic void step_issuer(input rd_req_t r);
    logic [31:0] busy_map;
    logic [31:0] count_w;
    logic [4:0]  free_slot;
    bit          found;
    int          n_entries;
    int          secs;
    int          bcf;
    int          i;
    found     = 1'b0;
    free_slot = '0;
    if (r.func == FUNC_START) begin
      // Lowest slot that is neither active nor issued.
      busy_map = r.active_slots | r.issued_slots;
      for (i = DEFAULT_SLOT_COUNT - 1; i >= 0; i--) begin
        if (!busy_map[i]) begin
          found     = 1'b1;
          free_slot = 5'(i);
        end
      end
      if (!found) begin
        close_run(5'd0, ST_NO_SLOT);
      end else begin
        // A zero count reads one sector; large counts saturate.
        count_w = (r.sector_count == '0) ? 32'd1 : 32'(r.sector_count);
        if (count_w > SECTOR_LIMIT) count_w = SECTOR_LIMIT;
        n_entries = (int'(count_w) - 1) / SPE + 1;
        for (i = 0; i < n_entries; i++) begin
          secs = (i + 1 < n_entries) ? SPE : int'(count_w) - (n_entries - 1) * SPE;
          bcf  = secs * 512 - 1;
          if (bcf > int'(BCF_MAX)) bcf = int'(BCF_MAX);
          post_result(pack_result(KIND_ENTRY, free_slot, 6'(i),
                                  r.buffer_address + 32'(i * ENTRY_BYTES), 13'(bcf),
                                  '0, '0, ST_OK, 1'b0));
        end
        run_slot   = free_slot;
        run_lba    = r.start_lba;
        run_count  = 11'(count_w);
        wait_count = 0;
        run_phase  = PH_READY;
      end
    end else if (run_phase == PH_READY) begin
      // Issue once the task file shows neither busy nor data request.
      if (wait_count >= limit_m) begin
        close_run(run_slot, ST_READY_TIMEOUT);
      end else begin
        wait_count++;
        if (!r.task_file_status[TF_BUSY_BIT] && !r.task_file_status[TF_DRQ_BIT]) begin
          post_result(pack_result(KIND_ISSUE, run_slot, '0, '0, '0, run_lba, run_count,
                                  ST_OK, 1'b0));
          run_phase  = PH_DONE;
          wait_count = 0;
        end
      end
    end else if (run_phase == PH_DONE) begin
      // A task file error wins over a still-set issue bit.
      if (wait_count >= limit_m) begin
        close_run(run_slot, ST_DONE_TIMEOUT);
      end else begin
        wait_count++;
        if (r.interrupt_status[IS_TFE_BIT]) close_run(run_slot, ST_TF_ERROR);
        else if (!r.issued_slots[run_slot]) close_run(run_slot, ST_OK);
      end
    end
  endfunction

  function automatic void check_field(input string what, input string field,
                                      input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s field %s: expected %0h, actual %0h", $time, what, field, want, got);
    end
  endfunction

  function automatic void compare_results(input rd_res_t want, input rd_res_t got,
                                          input string what);
    check_field(what, "kind", 64'(want.kind), 64'(got.kind));
    check_field(what, "slot", 64'(want.slot), 64'(got.slot));
    check_field(what, "entry_index", 64'(want.entry_index), 64'(got.entry_index));
    check_field(what, "data_address", 64'(want.data_address), 64'(got.data_address));
    check_field(what, "byte_count_field", 64'(want.byte_count_field),
                64'(got.byte_count_field));
    check_field(what, "fis_lba", 64'(want.fis_lba), 64'(got.fis_lba));
    check_field(what, "fis_count", 64'(want.fis_count), 64'(got.fis_count));
    check_field(what, "status", 64'(want.status), 64'(got.status));
    check_field(what, "last", 64'(want.last), 64'(got.last));
  endfunction

  // Offer one request, idling first at the current rate, and hold it until taken.
  task automatic push_request(input rd_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_bus  <= r;
    do @(posedge clk); while (!in_ready);
    step_issuer(r);
  endtask

  // Stop sending, wait for every queued result, then let a sample in flight finish.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout_limit(input logic [19:0] v);
    drain_results();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    limit_m = v;
  endtask

  function automatic rd_req_t start_req(input logic [31:0] buf_addr, input logic [47:0] lba,
                                        input logic [10:0] cnt, input logic [31:0] act,
                                        input logic [31:0] iss);
    return {FUNC_START, buf_addr, lba, cnt, act, iss, 8'h00, 32'h0};
  endfunction

  function automatic rd_req_t sample_req(input logic [31:0] act, input logic [31:0] iss,
                                         input logic [7:0] tfs, input logic [31:0] isr);
    return {FUNC_SAMPLE, 32'h0, 48'h0, 11'd0, act, iss, tfs, isr};
  endfunction

  function automatic void add_row(input rd_req_t r, input bit has_exp = 1'b0,
                                  input rd_res_t e = '0);
    directed_rows.push_back('{ROW_REQUEST, 20'h0, r, has_exp, e});
  endfunction

  function automatic void add_limit_row(input logic [19:0] v);
    directed_rows.push_back('{ROW_LIMIT, v, '0, 1'b0, '0});
  endfunction

  function automatic rd_req_t random_fields();
    rd_req_t r;
    r.func             = FUNC_SAMPLE;
    r.buffer_address   = $urandom;
    r.start_lba        = {16'($urandom), 32'($urandom)};
    r.sector_count     = 11'($urandom);
    r.active_slots     = $urandom;
    r.issued_slots     = $urandom;
    r.task_file_status = 8'($urandom);
    r.interrupt_status = $urandom;
    return r;
  endfunction

  // Start request: mostly short reads, some long or saturating ones.
  function automatic rd_req_t random_start();
    rd_req_t     r;
    logic [63:0] below;
    logic [63:0] above;
    logic [31:0] split;
    int          free_slot;
    int          pick;
    r      = random_fields();
    r.func = FUNC_START;
    pick   = $urandom_range(99);
    if (pick < 5) r.sector_count = '0;
    else if (pick < 12) r.sector_count = 11'($urandom_range(2047, 1024));
    else if (pick < 25) r.sector_count = 11'($urandom_range(1023, 49));
    else r.sector_count = 11'($urandom_range(48, 1));
    split = $urandom;
    if ($urandom_range(99) < 8) begin
      // Every slot taken by one bitmap or the other.
      r.active_slots = split;
      r.issued_slots = ~split | $urandom;
    end else begin
      // All slots below the chosen one are busy, the chosen one is free.
      free_slot      = $urandom_range(31);
      below          = (64'd1 << free_slot) - 64'd1;
      above          = ~((64'd2 << free_slot) - 64'd1);
      r.active_slots = 32'((split & below) | ($urandom & above));
      r.issued_slots = 32'((~split & below) | ($urandom & above));
    end
    return r;
  endfunction

  // Status sample shaped to the phase of the pending run.
  function automatic rd_req_t random_sample();
    rd_req_t r;
    r = random_fields();
    case (run_phase)
      PH_READY: begin
        if ($urandom_range(99) < 55) begin
          r.task_file_status[$urandom_range(1) ? TF_BUSY_BIT : TF_DRQ_BIT] = 1'b1;
        end else begin
          r.task_file_status[TF_BUSY_BIT] = 1'b0;
          r.task_file_status[TF_DRQ_BIT]  = 1'b0;
        end
      end
      PH_DONE: begin
        r.interrupt_status[IS_TFE_BIT] = ($urandom_range(99) < 10);
        r.issued_slots[run_slot]       = ($urandom_range(99) < 50);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly whole runs with random content; some stray samples and cut-off runs.
  task automatic run_random_phase(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 6) begin
        if (run_phase != PH_IDLE) sent++;
        push_request(random_sample());
      end else begin
        push_request(random_start());
        sent++;
        while (run_phase != PH_IDLE && sent < n_items && $urandom_range(99) >= 4) begin
          push_request(random_sample());
          sent++;
        end
      end
      if ($urandom_range(99) < 3) drain_results();
    end
  endtask

  // Receiver stalls at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Each result taken must match the oldest one still awaited.
  always @(posedge clk) begin
    rd_res_t got;
    got = rd_res_t'({kind, slot, entry_index, data_address, byte_count_field, fis_lba,
                     fis_count, status, last});
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual %0h", $time, got);
      end else begin
        compare_results(awaited_results.pop_front(), got, "result");
      end
    end
  end

  // Count cycles in which no request and no result is taken.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    // Directed requests: the ignored sample, every status, the extremes.
    add_row('1);
    add_row(start_req(32'h0, 48'h0, 11'd1, 32'h0, 32'h0), 1'b1,
            pack_result(KIND_ENTRY, 5'd0, 6'd0, 32'h0, 13'd511, '0, '0, ST_OK, 1'b0));
    add_row(sample_req(32'h0, 32'h0, 8'h80, 32'h0));
    add_row(sample_req(32'h0, 32'h0, 8'h08, 32'h0));
    // The issuing sample is not checked for completion or error.
    add_row(sample_req(32'hffff_ffff, 32'hffff_ffff, 8'h77, 32'h4000_0000), 1'b1,
            pack_result(KIND_ISSUE, 5'd0, '0, '0, '0, 48'h0, 11'd1, ST_OK, 1'b0));
    add_row(sample_req(32'h0, 32'h1, 8'h00, 32'h0));
    add_row(sample_req(32'hffff_ffff, 32'hffff_fffe, 8'hff, 32'hbfff_ffff), 1'b1,
            pack_result(KIND_FINISH, 5'd0, '0, '0, '0, '0, '0, ST_OK, 1'b1));
    add_row(start_req(32'h0, 48'h0, 11'd1, 32'hffff_0000, 32'h0000_ffff), 1'b1,
            pack_result(KIND_FINISH, 5'd0, '0, '0, '0, '0, '0, ST_NO_SLOT, 1'b1));
    add_row(start_req(32'hffff_ffff, 48'hffff_ffff_ffff, 11'd1024, 32'h7fff_ffff, 32'h0), 1'b1,
            pack_result(KIND_ENTRY, 5'd31, 6'd63, 32'h0007_dfff, 13'd8191, '0, '0, ST_OK, 1'b0));
    // A new start abandons the pending run; a zero count reads one sector.
    add_row(start_req(32'h1000, 48'h1234_5678_9abc, 11'd0, 32'hffff_fffe, 32'h0), 1'b1,
            pack_result(KIND_ENTRY, 5'd0, 6'd0, 32'h1000, 13'd511, '0, '0, ST_OK, 1'b0));
    add_row(sample_req(32'h0, 32'h0, 8'h00, 32'h0), 1'b1,
            pack_result(KIND_ISSUE, 5'd0, '0, '0, '0, 48'h1234_5678_9abc, 11'd1, ST_OK, 1'b0));
    add_row(sample_req(32'h0, 32'h1, 8'h00, 32'h4000_0000), 1'b1,
            pack_result(KIND_FINISH, 5'd0, '0, '0, '0, '0, '0, ST_TF_ERROR, 1'b1));
    add_row(start_req(32'h8000_0000, 48'hffff_ffff_ffff, 11'd2047, 32'h0, 32'h3));
    add_row(sample_req(32'h0, 32'h0, 8'h88, 32'h0));
    add_row(sample_req(32'h0, 32'h0, 8'h00, 32'h0), 1'b1,
            pack_result(KIND_ISSUE, 5'd2, '0, '0, '0, 48'hffff_ffff_ffff, 11'd1024, ST_OK, 1'b0));
    add_row(sample_req(32'h0, 32'hffff_ffff, 8'h00, 32'h0));
    add_row(sample_req(32'h0, 32'hffff_fffb, 8'h00, 32'h0), 1'b1,
            pack_result(KIND_FINISH, 5'd2, '0, '0, '0, '0, '0, ST_OK, 1'b1));
    // Timeout limit of one: one sample per wait.
    add_limit_row(20'd1);
    add_row(start_req(32'h10, 48'h5a5a, 11'd17, 32'h0, 32'h0));
    add_row(sample_req(32'h0, 32'h0, 8'hff, 32'h0));
    add_row(sample_req(32'h0, 32'h0, 8'h80, 32'h0), 1'b1,
            pack_result(KIND_FINISH, 5'd0, '0, '0, '0, '0, '0, ST_READY_TIMEOUT, 1'b1));
    add_row(start_req(32'hffff_f000, 48'h1, 11'd16, 32'h1f, 32'h0), 1'b1,
            pack_result(KIND_ENTRY, 5'd5, 6'd0, 32'hffff_f000, 13'd8191, '0, '0, ST_OK, 1'b0));
    add_row(sample_req(32'h0, 32'h0, 8'h00, 32'h0));
    add_row(sample_req(32'h0, 32'h20, 8'h00, 32'h0));
    add_row(sample_req(32'h0, 32'h20, 8'h00, 32'h0), 1'b1,
            pack_result(KIND_FINISH, 5'd5, '0, '0, '0, '0, '0, ST_DONE_TIMEOUT, 1'b1));

    send_idle_pct  = 25;
    recv_stall_pct = 60;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part; typed expectations also cross-check the predictor.
    foreach (directed_rows[k]) begin
      if (directed_rows[k].row_kind == ROW_LIMIT) begin
        set_timeout_limit(directed_rows[k].limit);
      end else begin
        push_request(directed_rows[k].req);
        if (directed_rows[k].has_exp)
          compare_results(directed_rows[k].exp, last_predicted, "directed row");
      end
    end

    // Sender idles lightly, receiver stalls often, timeout limit of one.
    set_timeout_limit(20'd1);
    run_random_phase(85);

    // Sender idles often, receiver stalls lightly, small timeout.
    send_idle_pct  = 60;
    recv_stall_pct = 25;
    set_timeout_limit(20'($urandom_range(6, 2)));
    run_random_phase(85);

    // No idling on either side, widest timeout.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_timeout_limit(TIMEOUT_RESET);
    run_random_phase(80);

    drain_results();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
